// ----- rtl/krl_pkg.sv -----
// Shared constants and types for the key repeat limiter with key FIFO.
package krl_pkg;

    // Number of keys the FIFO can hold.
    localparam int BUFFER_DEPTH = 16;

    // Ring pointer and fill count widths follow from the depth.
    localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

    // Field widths of one request and one result.
    localparam int ACTION_W = 2;
    localparam int KEY_W    = 8;
    localparam int TIMER_W  = 16;
    localparam int COUNT_W  = 5;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_STEP      = 2'd0,
        CFG_REPEAT_TIMEOUT = 2'd1
    } t_cfg_index;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK = 2'd0,
        ACT_PUSH = 2'd1,
        ACT_POP  = 2'd2
    } t_action;

    localparam logic [TIMER_W-1:0] TICK_STEP_RESET      = 16'd10;
    localparam logic [TIMER_W-1:0] REPEAT_TIMEOUT_RESET = 16'd500;
    localparam logic [TIMER_W-1:0] TIMER_MAX            = {TIMER_W{1'b1}};

endpackage

// ----- rtl/key_repeat_limiter_fifo.sv -----
// Top level: keypad auto-repeat limiter feeding a small key FIFO.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-----------------------------------
//  request  | in        | i_start, o_busy            | i_action, i_key_code
//  result   | out       | o_done (one-cycle strobe)  | o_popped_key, o_popped_valid,
//           |           |                            | o_count_before
//  config   | in        | i_cfg_valid, o_cfg_ready   | i_cfg_index, i_cfg_data
//
// A request is taken at every edge where i_start is high; o_busy is always low, so
// one request per cycle is sustained. Each request gives exactly one result, held
// first in the request register, then passed through the timer, FIFO and result
// register. The result register alone sets the rate of one per cycle.
// Reset is synchronous and active low; it empties the FIFO, stops the repeat
// timer, clears the last key and restores both configuration registers.
// The receiver cannot stall: o_done is a strobe and every result is taken at once.
module key_repeat_limiter_fifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [krl_pkg::ACTION_W-1:0]    i_action,
    input  logic [krl_pkg::KEY_W-1:0]       i_key_code,
    output logic                            o_done,
    output logic [krl_pkg::KEY_W-1:0]       o_popped_key,
    output logic                            o_popped_valid,
    output logic [krl_pkg::COUNT_W-1:0]     o_count_before,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [krl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [krl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // Configuration registers.
    logic [krl_pkg::TIMER_W-1:0] r_tick_step;
    logic [krl_pkg::TIMER_W-1:0] r_repeat_timeout;

    // Request register.
    logic                         r_in_valid;
    logic [krl_pkg::ACTION_W-1:0] r_action;
    logic [krl_pkg::KEY_W-1:0]    r_key;

    // Block state.
    logic [krl_pkg::KEY_W-1:0]   r_key_store [krl_pkg::BUFFER_DEPTH];
    logic [krl_pkg::PTR_W-1:0]   r_rd_ptr;
    logic [krl_pkg::PTR_W-1:0]   r_wr_ptr;
    logic [krl_pkg::CNT_W-1:0]   r_count;
    logic [krl_pkg::TIMER_W-1:0] r_timer;
    logic [krl_pkg::KEY_W-1:0]   r_prev_key;

    // Result register.
    logic                         r_done;
    logic [krl_pkg::KEY_W-1:0]    r_popped_key;
    logic                         r_popped_valid;
    logic [krl_pkg::COUNT_W-1:0]  r_count_before;

    // Next values.
    logic [krl_pkg::PTR_W-1:0]   n_rd_ptr;
    logic [krl_pkg::PTR_W-1:0]   n_wr_ptr;
    logic [krl_pkg::CNT_W-1:0]   n_count;
    logic [krl_pkg::TIMER_W-1:0] n_timer;
    logic [krl_pkg::KEY_W-1:0]   n_prev_key;
    logic [krl_pkg::KEY_W-1:0]   n_popped_key;
    logic                        n_popped_valid;

    logic                         enqueue;
    logic                         dequeue;
    logic                         fifo_full;
    logic                         fifo_empty;
    logic [krl_pkg::TIMER_W:0]    tick_sum;
    logic [krl_pkg::TIMER_W-1:0]  push_timer;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_step      <= krl_pkg::TICK_STEP_RESET;
            r_repeat_timeout <= krl_pkg::REPEAT_TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                krl_pkg::CFG_TICK_STEP:      r_tick_step      <= i_cfg_data;
                krl_pkg::CFG_REPEAT_TIMEOUT: r_repeat_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Request register: every request is captured, one per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= i_action;
        r_key    <= i_key_code;
    end

    assign fifo_full  = (r_count == krl_pkg::CNT_W'(krl_pkg::BUFFER_DEPTH));
    assign fifo_empty = (r_count == '0);

    // A tick advances a running timer and saturates instead of wrapping.
    assign tick_sum = {1'b0, r_timer} + {1'b0, r_tick_step};

    // Auto-repeat rule for a key report. A new key stops the timer. A repeat of
    // the same key starts a stopped timer, or is held off until the running
    // timer reaches the timeout, at which point the timer clears.
    always_comb begin
        if (r_key != r_prev_key) begin
            push_timer = '0;
        end else if (r_timer == '0) begin
            push_timer = r_tick_step;
        end else if (r_timer >= r_repeat_timeout) begin
            push_timer = '0;
        end else begin
            push_timer = r_timer;
        end
    end

    always_comb begin
        n_timer        = r_timer;
        n_prev_key     = r_prev_key;
        enqueue        = 1'b0;
        dequeue        = 1'b0;
        n_popped_key   = '0;
        n_popped_valid = 1'b0;
        if (r_in_valid) begin
            case (r_action)
                krl_pkg::ACT_TICK: begin
                    if (r_timer != '0) begin
                        n_timer = tick_sum[krl_pkg::TIMER_W] ? krl_pkg::TIMER_MAX
                                                             : tick_sum[krl_pkg::TIMER_W-1:0];
                    end
                end
                krl_pkg::ACT_PUSH: begin
                    n_timer    = push_timer;
                    n_prev_key = r_key;
                    // The key is queued only when the timer ends up stopped.
                    enqueue    = (push_timer == '0) && !fifo_full;
                end
                krl_pkg::ACT_POP: begin
                    if (!fifo_empty) begin
                        dequeue        = 1'b1;
                        n_popped_key   = r_key_store[r_rd_ptr];
                        n_popped_valid = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Ring pointers wrap at the buffer depth.
    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_count  = r_count;
        if (dequeue) begin
            n_rd_ptr = (r_rd_ptr == krl_pkg::PTR_W'(krl_pkg::BUFFER_DEPTH - 1))
                       ? '0 : r_rd_ptr + 1'b1;
            n_count  = r_count - 1'b1;
        end
        if (enqueue) begin
            n_wr_ptr = (r_wr_ptr == krl_pkg::PTR_W'(krl_pkg::BUFFER_DEPTH - 1))
                       ? '0 : r_wr_ptr + 1'b1;
            n_count  = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr   <= '0;
            r_wr_ptr   <= '0;
            r_count    <= '0;
            r_timer    <= '0;
            r_prev_key <= '0;
            r_done     <= 1'b0;
        end else begin
            r_rd_ptr   <= n_rd_ptr;
            r_wr_ptr   <= n_wr_ptr;
            r_count    <= n_count;
            r_timer    <= n_timer;
            r_prev_key <= n_prev_key;
            r_done     <= r_in_valid;
        end
    end

    // Key storage and result payload carry no reset.
    always_ff @(posedge i_clk) begin
        if (enqueue) begin
            r_key_store[r_wr_ptr] <= r_key;
        end
        r_popped_key   <= n_popped_key;
        r_popped_valid <= n_popped_valid;
        r_count_before <= krl_pkg::COUNT_W'(r_count);
    end

    assign o_done         = r_done;
    assign o_popped_key   = r_popped_key;
    assign o_popped_valid = r_popped_valid;
    assign o_count_before = r_count_before;

`ifndef SYNTH
    // The fill count never goes past the buffer depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= krl_pkg::CNT_W'(krl_pkg::BUFFER_DEPTH))
        else $error("key FIFO count exceeds depth");

    // Every captured request produces exactly one result on the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |=> o_done)
        else $error("request produced no result");

    // A successful pop always reports a nonempty FIFO before it.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_popped_valid) |-> (o_count_before != '0))
        else $error("pop returned a key from an empty FIFO");

    // A stopped timer does not start on a tick.
    a_tick_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_action == krl_pkg::ACT_TICK && r_timer == '0) |=> (r_timer == '0))
        else $error("tick started a stopped repeat timer");
`endif

endmodule
